[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable.
`define BCCC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// Stalled transaction keeps valid and payload.
`define BCCC_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error("%m: stalled transaction changed");

`endif

[src/bccc_pkg.sv]
package bccc_pkg;

  localparam int ORBIT_SLOTS_DEF = 3564;

  localparam int CROSS_W      = 48;
  localparam int SLOT_FIELD_W = 12;
  localparam int IDX_W        = 5;
  localparam int CNT_W        = 32;
  localparam int CMD_W        = 2;

  localparam int N_TRIG   = 4;
  localparam int N_CAT    = 6;
  localparam int N_CNT    = 26;
  localparam int CNT_ALL  = 24;
  localparam int CNT_LEAD = 25;

  localparam int CAT_A     = 0;
  localparam int CAT_B     = 1;
  localparam int CAT_C     = 2;
  localparam int CAT_E     = 3;
  localparam int CAT_LEAD  = 4;
  localparam int CAT_SLEAD = 5;

  localparam int LEAD_GAP_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_GAP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_NO_T0 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CATEGORY_EN   = 2'd2;

  localparam logic [LEAD_GAP_W-1:0] LEAD_GAP_RST = 4'd5;
  localparam logic [N_CAT-1:0]      CAT_EN_RST   = 6'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_PROCESS = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [IDX_W-1:0]        counter_index;
    logic                    fwd_trigger;
    logic                    t0_ce_trigger;
    logic                    vertex_trigger;
    logic                    has_fwd_hit;
    logic                    has_t0_hit;
    logic [CROSS_W-1:0]      global_crossing;
    logic                    beam_c_filled;
    logic                    beam_a_filled;
    logic [SLOT_FIELD_W-1:0] slot;
  } in_item_t;

  localparam int IN_DATA_W = $bits(in_item_t);

  typedef struct packed {
    logic [5:0]        pad;
    logic [CNT_W-1:0]  count_value;
    logic [N_TRIG-1:0] trigger_flags;
    logic [N_CAT-1:0]  category_flags;
  } out_item_t;

  localparam int OUT_DATA_W = $bits(out_item_t);

  typedef struct packed {
    logic             clear;
    logic             inc_start;
    logic [N_CNT-1:0] inc_mask;
    logic             rd_req;
    logic [IDX_W-1:0] rd_idx;
  } cnt_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] rd_data;
  } cnt_stat_t;

endpackage

[src/bccc_ram.sv]
module bccc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/bccc_slot_mod.sv]
module bccc_slot_mod import bccc_pkg::*; #(
  parameter int ORBIT_SLOTS = ORBIT_SLOTS_DEF,
  localparam int SLOT_W = (ORBIT_SLOTS > 1) ? $clog2(ORBIT_SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CROSS_W-1:0] value_i,
  output logic               done_o,
  output logic [SLOT_W-1:0]  rem_o
);

  localparam int CHUNK_W  = 12;
  localparam int PROD_W   = 2 * CHUNK_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int RECIP_SH = 31;
  localparam int RECIP_W  = 32;
  localparam int MUL_W    = SUM_W + RECIP_W;

  localparam int     R12_I   = (1 << CHUNK_W) % ORBIT_SLOTS;
  localparam int     R24_I   = (R12_I * R12_I) % ORBIT_SLOTS;
  localparam int     R36_I   = (R24_I * R12_I) % ORBIT_SLOTS;
  localparam longint RECIP_I = (longint'(1) << RECIP_SH) / ORBIT_SLOTS;

  localparam logic [PROD_W-1:0]  R12   = PROD_W'(R12_I);
  localparam logic [PROD_W-1:0]  R24   = PROD_W'(R24_I);
  localparam logic [PROD_W-1:0]  R36   = PROD_W'(R36_I);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_I);
  localparam logic [SUM_W-1:0]   MOD_S = SUM_W'(ORBIT_SLOTS);
  localparam logic [SLOT_W:0]    MOD_R = (SLOT_W + 1)'(ORBIT_SLOTS);

  logic [CROSS_W-1:0] val_q;
  logic [PROD_W-1:0]  prod3, prod2, prod1;
  logic [SUM_W-1:0]   sum_q, sum_d, keep_q, quo_q, quo_d, part, rest;
  logic [MUL_W-1:0]   recip_prod;
  logic [SLOT_W:0]    raw_q, raw_d, sub;
  logic [SLOT_W-1:0]  rem_q, rem_d;
  logic [3:0]         stage_q;
  logic               done_q;

  always_comb begin
    prod3 = {{(PROD_W-CHUNK_W){1'b0}}, val_q[3*CHUNK_W +: CHUNK_W]} * R36;
    prod2 = {{(PROD_W-CHUNK_W){1'b0}}, val_q[2*CHUNK_W +: CHUNK_W]} * R24;
    prod1 = {{(PROD_W-CHUNK_W){1'b0}}, val_q[CHUNK_W +: CHUNK_W]} * R12;
    sum_d = SUM_W'(prod3) + SUM_W'(prod2) + SUM_W'(prod1) + SUM_W'(val_q[CHUNK_W-1:0]);
    recip_prod = {{RECIP_W{1'b0}}, sum_q} * {{SUM_W{1'b0}}, RECIP};
    quo_d = recip_prod[RECIP_SH +: SUM_W];
    part  = quo_q * MOD_S;
    rest  = keep_q - part;
    raw_d = rest[SLOT_W:0];
    sub   = raw_q - MOD_R;
    rem_d = (raw_q >= MOD_R) ? sub[SLOT_W-1:0] : raw_q[SLOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= {stage_q[2:0], start_i};
      done_q  <= stage_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
    end
    if (stage_q[0]) begin
      sum_q <= sum_d;
    end
    if (stage_q[1]) begin
      quo_q  <= quo_d;
      keep_q <= sum_q;
    end
    if (stage_q[2]) begin
      raw_q <= raw_d;
    end
    if (stage_q[3]) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[src/bccc_cnt_bank.sv]
module bccc_cnt_bank import bccc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cnt_ctrl_t ctrl_i,
  output cnt_stat_t stat_o
);

  localparam int CNT_AW = $clog2(N_CNT);

  logic [N_CNT-1:0]  valid_q, pend_q, pick;
  logic [CNT_AW-1:0] pick_idx, raddr, wr_idx_q;
  logic              wr_pend_q, rd_ok_q, issue, rd_in_range;
  logic [CNT_W-1:0]  rdata, old_val, wdata;

  assign pick  = pend_q & (~pend_q + 1'b1);
  assign issue = |pend_q;

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < N_CNT; i++) begin
      pick_idx = pick_idx | (pick[i] ? CNT_AW'(i) : '0);
    end
  end

  assign rd_in_range = (ctrl_i.rd_idx < IDX_W'(N_CNT));

  always_comb begin
    raddr = pick_idx;
    if (ctrl_i.rd_req) begin
      raddr = rd_in_range ? ctrl_i.rd_idx[CNT_AW-1:0] : '0;
    end
  end

  assign old_val = valid_q[wr_idx_q] ? rdata : '0;
  assign wdata   = (&old_val) ? old_val : old_val + 1'b1;

  bccc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (N_CNT)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pend_q),
    .waddr_i (wr_idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      pend_q    <= '0;
      wr_pend_q <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        valid_q <= '0;
      end else if (wr_pend_q) begin
        valid_q[wr_idx_q] <= 1'b1;
      end
      if (ctrl_i.inc_start) begin
        pend_q <= ctrl_i.inc_mask;
      end else if (issue) begin
        pend_q <= pend_q & ~pick;
      end
      wr_pend_q <= issue && !ctrl_i.inc_start;
      rd_ok_q   <= ctrl_i.rd_req && rd_in_range && valid_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    wr_idx_q <= pick_idx;
  end

  assign stat_o.busy    = issue | wr_pend_q;
  assign stat_o.rd_data = rd_ok_q ? rdata : '0;

endmodule

[src/bunch_crossing_classifier_counter.sv]
// Bunch-crossing classifier and counter. Load the beam pattern slot by slot (cmd 0) before
// processing crossings (cmd 1); read a counter by index (cmd 2) or clear all counters and the
// activity mark (cmd 3). One item is worked on at a time and gives one result transaction.
// A load or a clear goes straight to its result; a read first waits on the counter memory.
// A crossing finds its slot in a pipelined remainder unit (fold by constants, reciprocal
// multiply, one correction); the pattern memory then gives one slot per cycle for the
// lead_gap look-back (cut short at the first slot with both beams, skipped when the slot
// itself lacks a beam or lead_gap is 0), and the counter memory does one read-modify-write
// per cycle for each counter the crossing hits (1 to 14). A result that finds the output
// register still full adds a stall. The next item is taken while a result still waits on
// the output.
module bunch_crossing_classifier_counter import bccc_pkg::*; #(
  parameter int ORBIT_SLOTS = ORBIT_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot, beam_a_filled, beam_c_filled, global_crossing, has_t0_hit, has_fwd_hit,
  // vertex_trigger, t0_ce_trigger, fwd_trigger, counter_index
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // category_flags, trigger_flags, count_value, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SLOT_W = (ORBIT_SLOTS > 1) ? $clog2(ORBIT_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ORBIT_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_PAT_RD,
    S_PAT_CHK,
    S_SCAN,
    S_EVAL,
    S_INC,
    S_RD_WAIT,
    S_FINISH
  } state_e;

  function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
    prev_slot = (s == '0) ? LAST_SLOT : s - 1'b1;
  endfunction

  state_e                state_q, state_d;
  in_item_t              item_q, item_d, in_item;
  cmd_e                  in_cmd;
  logic [SLOT_W-1:0]     slot_q, slot_d, addr_q, addr_d;
  logic [1:0]            pat_q, pat_d;
  logic                  lead_q, lead_d, spend_q, spend_d;
  logic [LEAD_GAP_W-1:0] issue_q, issue_d;
  logic [CROSS_W-1:0]    last_act_q, last_act_d, diff;
  logic [LEAD_GAP_W-1:0] lead_gap_q, lead_gap_d;
  logic                  req_t0_q, req_t0_d;
  logic [N_CAT-1:0]      cat_en_q, cat_en_d;
  out_item_t             res_q, res_d, out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  in_acc, pat_we, slot_ok, mod_start, mod_done, sl;
  logic [SLOT_W-1:0]     mod_rem, pat_raddr;
  logic [1:0]            pat_rdata;
  logic [N_CAT-1:0]      cats;
  logic [N_TRIG-1:0]     trigs;
  logic [N_CNT-1:0]      inc_mask;
  cnt_ctrl_t             cnt_ctrl;
  cnt_stat_t             cnt_stat;

  assign in_item       = in_item_t'(s_axis_tdata);
  assign in_cmd        = cmd_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_ok       = ({1'b0, in_item.slot} < (SLOT_FIELD_W + 1)'(ORBIT_SLOTS));
  assign pat_we        = in_acc && (in_cmd == CMD_LOAD) && slot_ok;
  assign mod_start     = in_acc && (in_cmd == CMD_PROCESS);

  bccc_slot_mod #(
    .ORBIT_SLOTS (ORBIT_SLOTS)
  ) u_slot_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (in_item.global_crossing),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  bccc_ram #(
    .WIDTH (2),
    .DEPTH (ORBIT_SLOTS)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (in_item.slot[SLOT_W-1:0]),
    .wdata_i ({in_item.beam_c_filled, in_item.beam_a_filled}),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  bccc_cnt_bank u_cnt_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cnt_ctrl),
    .stat_o (cnt_stat)
  );

  always_comb begin
    diff = item_q.global_crossing - last_act_q;
    sl   = (&pat_q) && !(item_q.global_crossing < last_act_q)
           && !(diff < CROSS_W'(lead_gap_q));
    cats[CAT_A]     = pat_q[0] && !pat_q[1];
    cats[CAT_B]     = pat_q[0] && pat_q[1];
    cats[CAT_C]     = !pat_q[0] && pat_q[1];
    cats[CAT_E]     = !pat_q[0] && !pat_q[1];
    cats[CAT_LEAD]  = lead_q;
    cats[CAT_SLEAD] = sl;
    trigs = {item_q.fwd_trigger, item_q.t0_ce_trigger, item_q.vertex_trigger, 1'b1};
    for (int t = 0; t < N_TRIG; t++) begin
      for (int k = 0; k < N_CAT; k++) begin
        inc_mask[t*N_CAT+k] = trigs[t] && cats[k] && cat_en_q[k];
      end
    end
    inc_mask[CNT_ALL]  = 1'b1;
    inc_mask[CNT_LEAD] = lead_q;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    slot_d      = slot_q;
    addr_d      = addr_q;
    pat_d       = pat_q;
    lead_d      = lead_q;
    spend_d     = spend_q;
    issue_d     = issue_q;
    last_act_d  = last_act_q;
    lead_gap_d  = lead_gap_q;
    req_t0_d    = req_t0_q;
    cat_en_d    = cat_en_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cnt_ctrl    = '0;
    pat_raddr   = slot_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEAD_GAP:      lead_gap_d = cfg_data_i[LEAD_GAP_W-1:0];
        CFG_REQUIRE_NO_T0: req_t0_d   = cfg_data_i[0];
        CFG_CATEGORY_EN:   cat_en_d   = cfg_data_i[N_CAT-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_d = in_item;
          res_d  = '0;
          case (in_cmd)
            CMD_LOAD: begin
              state_d = S_FINISH;
            end
            CMD_PROCESS: begin
              state_d = S_MOD;
            end
            CMD_READ: begin
              cnt_ctrl.rd_req = 1'b1;
              cnt_ctrl.rd_idx = in_item.counter_index;
              state_d         = S_RD_WAIT;
            end
            CMD_CLEAR: begin
              cnt_ctrl.clear = 1'b1;
              last_act_d     = '0;
              state_d        = S_FINISH;
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          slot_d  = mod_rem;
          state_d = S_PAT_RD;
        end
      end
      S_PAT_RD: begin
        state_d = S_PAT_CHK;
      end
      S_PAT_CHK: begin
        pat_d   = pat_rdata;
        lead_d  = &pat_rdata;
        addr_d  = prev_slot(slot_q);
        issue_d = '0;
        spend_d = 1'b0;
        state_d = ((&pat_rdata) && (lead_gap_q != '0)) ? S_SCAN : S_EVAL;
      end
      S_SCAN: begin
        pat_raddr = addr_q;
        if (spend_q && (&pat_rdata)) begin
          lead_d  = 1'b0;
          state_d = S_EVAL;
        end else if (issue_q == lead_gap_q) begin
          state_d = S_EVAL;
        end else begin
          addr_d  = prev_slot(addr_q);
          issue_d = issue_q + 1'b1;
          spend_d = 1'b1;
        end
      end
      S_EVAL: begin
        cnt_ctrl.inc_start = 1'b1;
        cnt_ctrl.inc_mask  = inc_mask;
        if (item_q.has_fwd_hit || (req_t0_q && item_q.has_t0_hit)) begin
          last_act_d = item_q.global_crossing;
        end
        res_d.category_flags = cats;
        res_d.trigger_flags  = trigs;
        state_d              = S_INC;
      end
      S_INC: begin
        if (!cnt_stat.busy) begin
          state_d = S_FINISH;
        end
      end
      S_RD_WAIT: begin
        res_d.count_value = cnt_stat.rd_data;
        state_d           = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      slot_q      <= '0;
      addr_q      <= '0;
      pat_q       <= '0;
      lead_q      <= 1'b0;
      spend_q     <= 1'b0;
      issue_q     <= '0;
      last_act_q  <= '0;
      lead_gap_q  <= LEAD_GAP_RST;
      req_t0_q    <= 1'b0;
      cat_en_q    <= CAT_EN_RST;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      slot_q      <= slot_d;
      addr_q      <= addr_d;
      pat_q       <= pat_d;
      lead_q      <= lead_d;
      spend_q     <= spend_d;
      issue_q     <= issue_d;
      last_act_q  <= last_act_d;
      lead_gap_q  <= lead_gap_d;
      req_t0_q    <= req_t0_d;
      cat_en_q    <= cat_en_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

[src/bccc_checker.sv]
`include "assert_macros.svh"

module bccc_checker import bccc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  out_item_t res;

  assign res = out_item_t'(m_axis_tdata);

  `BCCC_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata)

  `BCCC_ASSERT(a_one_item, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

  `BCCC_ASSERT(a_one_class, clk_i, rst_ni, (m_axis_tvalid && res.trigger_flags[0]) |-> $onehot(res.category_flags[3:0]))

  `BCCC_ASSERT(a_lead_is_b, clk_i, rst_ni, (m_axis_tvalid && (res.category_flags[CAT_LEAD] || res.category_flags[CAT_SLEAD])) |-> res.category_flags[CAT_B])

endmodule

bind bunch_crossing_classifier_counter bccc_checker u_bccc_checker (.*);

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bccc_pkg::*;

  localparam int ORBIT       = ORBIT_SLOTS_DEF;
  localparam int RUN_LIMIT   = 1_000_000;
  localparam int TAIL_CYCLES = 100;
  localparam int LOOK_BACK   = 15;
  localparam int WINDOW      = 60;
  localparam logic [CROSS_W-1:0] CROSS_MAX = '1;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]      s_axis_tuser  = CMD_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_LEAD_GAP;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  logic [1:0]            beam_map [ORBIT];
  bit                    slot_loaded [ORBIT];
  logic [CROSS_W-1:0]    activity_mark;
  logic [CNT_W-1:0]      tally [N_CNT];
  logic [LEAD_GAP_W-1:0] gap_reg;
  logic                  t0_activity_reg;
  logic [N_CAT-1:0]      cat_en_reg;
  out_item_t             expected_q [$];
  out_item_t             got_item;
  out_item_t             want_item;
  logic [CROSS_W-1:0]    walk_crossing;
  int                    n_fail;
  int                    src_idle_pct;
  int                    snk_idle_pct;
  int                    cycle_count;

  always #10 clk_i = ~clk_i;

  bunch_crossing_classifier_counter #(
    .ORBIT_SLOTS(ORBIT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  function automatic void bump_tally(int idx);
    if (tally[idx] != '1) tally[idx]++;
  endfunction

  function automatic void predict_item(cmd_e cmd, in_item_t it);
    out_item_t          res;
    int                 s;
    int                 prev;
    logic               a;
    logic               c;
    logic               b;
    logic               lead;
    logic               slead;
    logic [N_CAT-1:0]   cats;
    logic [N_TRIG-1:0]  trigs;
    res = '0;
    case (cmd)
      CMD_LOAD: begin
        if (it.slot < ORBIT) begin
          beam_map[it.slot]    = {it.beam_c_filled, it.beam_a_filled};
          slot_loaded[it.slot] = 1'b1;
        end
      end
      CMD_PROCESS: begin
        s = int'(it.global_crossing % CROSS_W'(ORBIT));
        a = beam_map[s][0];
        c = beam_map[s][1];
        b = a & c;
        lead = b;
        if (b) begin
          for (int j = 1; j <= gap_reg; j++) begin
            prev = (s + ORBIT - j % ORBIT) % ORBIT;
            if (beam_map[prev] == 2'b11) begin
              lead = 1'b0;
              break;
            end
          end
        end
        slead = b && (it.global_crossing >= activity_mark) &&
                ((it.global_crossing - activity_mark) >= gap_reg);
        if (it.has_fwd_hit || (t0_activity_reg && it.has_t0_hit))
          activity_mark = it.global_crossing;
        cats            = '0;
        cats[CAT_A]     = a & ~c;
        cats[CAT_B]     = b;
        cats[CAT_C]     = ~a & c;
        cats[CAT_E]     = ~a & ~c;
        cats[CAT_LEAD]  = lead;
        cats[CAT_SLEAD] = slead;
        trigs = {it.fwd_trigger, it.t0_ce_trigger, it.vertex_trigger, 1'b1};
        bump_tally(CNT_ALL);
        if (lead) bump_tally(CNT_LEAD);
        for (int t = 0; t < N_TRIG; t++) begin
          for (int k = 0; k < N_CAT; k++) begin
            if (trigs[t] && cats[k] && cat_en_reg[k]) bump_tally(t * N_CAT + k);
          end
        end
        res.category_flags = cats;
        res.trigger_flags  = trigs;
      end
      CMD_READ: begin
        if (it.counter_index < N_CNT) res.count_value = tally[it.counter_index];
      end
      default: begin
        foreach (tally[i]) tally[i] = '0;
        activity_mark = '0;
      end
    endcase
    expected_q.push_back(res);
  endfunction

  function automatic bit slot_ready(int s);
    for (int j = 0; j <= LOOK_BACK; j++) begin
      if (!slot_loaded[(s + ORBIT - j) % ORBIT]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance to the next crossing whose slot and look-back slots hold a pattern
  function automatic logic [CROSS_W-1:0] settle_crossing(logic [CROSS_W-1:0] g);
    for (int n = 0; n < ORBIT; n++) begin
      if (slot_ready(int'(g % CROSS_W'(ORBIT)))) break;
      g++;
    end
    return g;
  endfunction

  function automatic logic [1:0] pick_pattern();
    if ($urandom_range(0, 9) == 0) return 2'b11;
    return 2'($urandom_range(0, 2));
  endfunction

  function automatic in_item_t noise_item();
    return in_item_t'({$urandom(), $urandom(), $urandom()});
  endfunction

  task automatic send_item(cmd_e cmd, in_item_t it);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(cmd, it);
  endtask

  task automatic send_load(int slot, logic [1:0] pattern);
    in_item_t it;
    it               = noise_item();
    it.slot          = SLOT_FIELD_W'(slot);
    it.beam_a_filled = pattern[0];
    it.beam_c_filled = pattern[1];
    send_item(CMD_LOAD, it);
  endtask

  // sig: t0 hit, forward hit, vertex, T0 C-or-E, forward trigger from bit 0 up
  task automatic send_crossing(logic [CROSS_W-1:0] g, logic [4:0] sig);
    in_item_t it;
    it                 = noise_item();
    it.global_crossing = g;
    it.has_t0_hit      = sig[0];
    it.has_fwd_hit     = sig[1];
    it.vertex_trigger  = sig[2];
    it.t0_ce_trigger   = sig[3];
    it.fwd_trigger     = sig[4];
    send_item(CMD_PROCESS, it);
  endtask

  task automatic send_read(int idx);
    in_item_t it;
    it               = noise_item();
    it.counter_index = IDX_W'(idx);
    send_item(CMD_READ, it);
  endtask

  task automatic send_clear();
    send_item(CMD_CLEAR, noise_item());
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_LEAD_GAP:      gap_reg         = val[LEAD_GAP_W-1:0];
      CFG_REQUIRE_NO_T0: t0_activity_reg = val[0];
      CFG_CATEGORY_EN:   cat_en_reg      = val[N_CAT-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(int gap, logic t0, logic [N_CAT-1:0] en);
    wait_drain();
    write_reg(CFG_LEAD_GAP, CFG_DATA_W'(gap));
    write_reg(CFG_REQUIRE_NO_T0, CFG_DATA_W'(t0));
    write_reg(CFG_CATEGORY_EN, CFG_DATA_W'(en));
  endtask

  task automatic dump_counters();
    for (int i = 0; i < N_CNT; i++) send_read(i);
  endtask

  // fill the slots around the orbit wrap and those of the last crossing number
  task automatic test_pattern_load();
    int top;
    top = int'(CROSS_MAX % CROSS_W'(ORBIT));
    for (int s = 0; s < WINDOW; s++) send_load(s, pick_pattern());
    for (int s = ORBIT - WINDOW; s < ORBIT; s++) send_load(s, pick_pattern());
    for (int j = LOOK_BACK + 4; j >= 0; j--)
      send_load((top + ORBIT - j) % ORBIT, pick_pattern());
  endtask

  task automatic test_slot_corners();
    apply_config(3, 1'b1, '1);
    send_load(0, 2'b00);
    send_load(ORBIT, 2'b11);
    send_load(4095, 2'b11);
    send_load(1, 2'b11);
    send_load(ORBIT - 1, 2'b01);
    send_crossing('0, 5'b11111);
    send_crossing(CROSS_MAX, 5'b00000);
    send_crossing(CROSS_W'(ORBIT - 1), 5'b01101);
    send_crossing(CROSS_W'(ORBIT - 2), 5'b10100);
    send_crossing(CROSS_W'(ORBIT + 1), 5'b11000);
    send_crossing(CROSS_W'(ORBIT + 2), 5'b00110);
    send_read(CNT_ALL);
    send_read(CNT_LEAD);
    send_read(0);
    send_read(N_TRIG * N_CAT - 1);
    send_read(N_CNT);
    send_read(31);
    send_clear();
    send_read(CNT_ALL);
    send_crossing(CROSS_W'(ORBIT + 1), 5'b00100);
    send_read(N_CAT + CAT_B);
  endtask

  task automatic test_random_traffic(int n_items);
    int                 r;
    int                 pick;
    logic [CROSS_W-1:0] g;
    logic [4:0]         sig;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)      g = walk_crossing + $urandom_range(0, gap_reg + 3);
        else if (pick < 90) g = CROSS_W'({$urandom(), $urandom()});
        else                g = walk_crossing - $urandom_range(0, 20);
        g             = settle_crossing(g);
        walk_crossing = g;
        sig[4:2]      = 3'($urandom_range(0, 7));
        sig[1]        = ($urandom_range(0, 99) < 30);
        sig[0]        = ($urandom_range(0, 99) < 30);
        send_crossing(g, sig);
      end else if (r < 80) begin
        send_read($urandom_range(0, 31));
      end else if (r < 83) begin
        send_clear();
      end else if (r < 95) begin
        pick = $urandom_range(0, 2 * WINDOW - 1);
        send_load(pick < WINDOW ? pick : ORBIT - 2 * WINDOW + pick, pick_pattern());
      end else begin
        send_load($urandom_range(0, 4095), pick_pattern());
      end
    end
    dump_counters();
  endtask

  task automatic run_idle_phase(int src_pct, int snk_pct);
    wait_drain();
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int k = 0; k < 4; k++) begin
      case (k)
        0:       apply_config(0, 1'b0, '1);
        1:       apply_config(15, 1'b1, '1);
        2:       apply_config($urandom_range(0, 15), 1'($urandom_range(0, 1)),
                              N_CAT'($urandom_range(0, 63)));
        default: apply_config(15, 1'b0, '0);
      endcase
      test_random_traffic(125);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_item = out_item_t'(m_axis_tdata);
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_axis_tdata);
        n_fail++;
      end else begin
        want_item = expected_q.pop_front();
        if (got_item.category_flags !== want_item.category_flags) begin
          $error("category_flags: expected %h, got %h",
                 want_item.category_flags, got_item.category_flags);
          n_fail++;
        end
        if (got_item.trigger_flags !== want_item.trigger_flags) begin
          $error("trigger_flags: expected %h, got %h",
                 want_item.trigger_flags, got_item.trigger_flags);
          n_fail++;
        end
        if (got_item.count_value !== want_item.count_value) begin
          $error("count_value: expected %h, got %h",
                 want_item.count_value, got_item.count_value);
          n_fail++;
        end
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    foreach (beam_map[i]) beam_map[i] = 2'b00;
    foreach (tally[i]) tally[i] = '0;
    activity_mark   = '0;
    gap_reg         = LEAD_GAP_RST;
    t0_activity_reg = 1'b0;
    cat_en_reg      = CAT_EN_RST;
    walk_crossing   = '0;
    n_fail          = 0;
    cycle_count     = 0;
    src_idle_pct    = 27;
    snk_idle_pct    = 58;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pattern_load();
    test_slot_corners();
    run_idle_phase(27, 58);
    run_idle_phase(58, 27);
    run_idle_phase(0, 0);
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
